// ===== rtl/luds_pkg.sv =====
// Shared types and constants of the lenient UTF-8 stream decoder.
`default_nettype none
package luds_pkg;

	localparam int unsigned MaxResults = 4;

	localparam logic [7:0] AsciiLimit = 8'h80;
	localparam logic [7:0] Lead2Mask  = 8'he0;
	localparam logic [7:0] Lead2Code  = 8'hc0;
	localparam logic [7:0] Lead3Mask  = 8'hf0;
	localparam logic [7:0] Lead3Code  = 8'he0;
	localparam logic [7:0] Lead4Mask  = 8'hf8;
	localparam logic [7:0] Lead4Code  = 8'hf0;
	localparam logic [7:0] ContMask   = 8'hc0;
	localparam logic [7:0] ContCode   = 8'h80;
	localparam logic [7:0] PayloadMask = 8'h3f;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        passed_raw;
		logic        run_last;
		logic        text_done;
	} out_item_t;

	// All results caused by one input byte.
	typedef struct packed {
		logic [MaxResults-1:0][20:0] code;
		logic [MaxResults-1:0]       raw;
		logic [2:0]                  count;
		logic                        end_of_text;
	} batch_t;

endpackage
`default_nettype wire

// ===== rtl/luds_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
`default_nettype none
interface luds_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/lenient_utf8_stream_decoder_unit.sv =====
// A result passes through the queue, then the output register, after its byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and the output is not stalled.
// A byte that gives several results holds the output for one transaction per result; the batch queue absorbs that.
// Reset clears the open sequence, empties the queue and drops any pending result.
`default_nettype none
module lenient_utf8_stream_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	luds_stream_if.sink   byte_stream,
	luds_stream_if.source point_stream
);

	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	luds_pkg::batch_t push_batch;
	luds_pkg::batch_t head;

	luds_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.full        (full),
		.push        (push),
		.batch       (push_batch)
	);

	luds_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_batch (push_batch),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.head       (head)
	);

	luds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.point_stream (point_stream)
	);

endmodule
`default_nettype wire

// ===== rtl/luds_front.sv =====
// Front end: takes bytes, tracks the open sequence and builds the result batch of each byte.
`default_nettype none
module luds_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	luds_stream_if.sink    byte_stream,
	input  wire logic      full,
	output logic           push,
	output luds_pkg::batch_t batch
);

	logic [7:0] lead_q;
	logic [1:0][5:0] cont_q;
	logic [1:0] need_q;
	logic [1:0] held_q;

	logic [7:0] lead_d;
	logic [1:0][5:0] cont_d;
	logic [1:0] need_d;
	logic [1:0] held_d;

	logic accept;
	logic [20:0] assembled;

	assign byte_stream.ready = !full;
	assign accept = byte_stream.valid && !full;

	always_comb begin
		logic [7:0] b;
		b = byte_stream.payload.data_byte;
		unique case (need_q)
			2'd1: assembled = {10'd0, lead_q[4:0], b[5:0]};
			2'd2: assembled = {5'd0, lead_q[3:0], cont_q[0], b[5:0]};
			default: assembled = {lead_q[2:0], cont_q[0], cont_q[1], b[5:0]};
		endcase
	end

	always_comb begin
		logic [7:0] b;
		logic [2:0] cnt;
		logic       fresh;
		b = byte_stream.payload.data_byte;
		cnt = 3'd0;
		fresh = 1'b0;
		lead_d = lead_q;
		cont_d = cont_q;
		need_d = need_q;
		held_d = held_q;
		batch.code = '0;
		batch.raw = '0;
		if (need_q != 2'd0) begin
			if ((b & luds_pkg::ContMask) == luds_pkg::ContCode) begin
				if ({1'b0, held_q} + 3'd1 >= {1'b0, need_q}) begin
					batch.code[cnt[1:0]] = assembled;
					cnt = cnt + 3'd1;
					lead_d = '0;
					cont_d = '0;
					need_d = '0;
					held_d = '0;
				end else begin
					cont_d[held_q[0]] = b[5:0];
					held_d = held_q + 2'd1;
				end
			end else begin
				batch.code[cnt[1:0]] = {13'd0, lead_q};
				batch.raw[cnt[1:0]] = 1'b1;
				cnt = cnt + 3'd1;
				if (held_q >= 2'd1) begin
					batch.code[cnt[1:0]] = {13'd0, 2'b10, cont_q[0]};
					batch.raw[cnt[1:0]] = 1'b1;
					cnt = cnt + 3'd1;
				end
				if (held_q >= 2'd2) begin
					batch.code[cnt[1:0]] = {13'd0, 2'b10, cont_q[1]};
					batch.raw[cnt[1:0]] = 1'b1;
					cnt = cnt + 3'd1;
				end
				lead_d = '0;
				cont_d = '0;
				need_d = '0;
				held_d = '0;
				fresh = 1'b1;
			end
		end else begin
			fresh = 1'b1;
		end
		if (fresh) begin
			priority if (b < luds_pkg::AsciiLimit) begin
				batch.code[cnt[1:0]] = {13'd0, b};
				cnt = cnt + 3'd1;
			end else if ((b & luds_pkg::Lead2Mask) == luds_pkg::Lead2Code) begin
				lead_d = b;
				need_d = 2'd1;
				held_d = 2'd0;
			end else if ((b & luds_pkg::Lead3Mask) == luds_pkg::Lead3Code) begin
				lead_d = b;
				need_d = 2'd2;
				held_d = 2'd0;
			end else if ((b & luds_pkg::Lead4Mask) == luds_pkg::Lead4Code) begin
				lead_d = b;
				need_d = 2'd3;
				held_d = 2'd0;
			end else begin
				batch.code[cnt[1:0]] = {13'd0, b};
				batch.raw[cnt[1:0]] = 1'b1;
				cnt = cnt + 3'd1;
			end
		end
		if (byte_stream.payload.end_of_text && need_d != 2'd0) begin
			batch.code[cnt[1:0]] = {13'd0, lead_d};
			batch.raw[cnt[1:0]] = 1'b1;
			cnt = cnt + 3'd1;
			if (held_d >= 2'd1) begin
				batch.code[cnt[1:0]] = {13'd0, 2'b10, cont_d[0]};
				batch.raw[cnt[1:0]] = 1'b1;
				cnt = cnt + 3'd1;
			end
			if (held_d >= 2'd2) begin
				batch.code[cnt[1:0]] = {13'd0, 2'b10, cont_d[1]};
				batch.raw[cnt[1:0]] = 1'b1;
				cnt = cnt + 3'd1;
			end
			lead_d = '0;
			cont_d = '0;
			need_d = '0;
			held_d = '0;
		end
		batch.count = cnt;
		batch.end_of_text = byte_stream.payload.end_of_text;
	end

	assign push = accept && (batch.count != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			cont_q <= '0;
			need_q <= '0;
			held_q <= '0;
		end else if (accept) begin
			lead_q <= lead_d;
			cont_q <= cont_d;
			need_q <= need_d;
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/luds_queue.sv =====
// Short queue of result batches between the front end and the back end.
`default_nettype none
module luds_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire luds_pkg::batch_t push_batch,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output luds_pkg::batch_t      head
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	luds_pkg::batch_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_batch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + CntW'(1);
				2'b01: count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/luds_back.sv =====
// Back end: walks through each batch and hands out one result per transaction.
`default_nettype none
module luds_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire luds_pkg::batch_t head,
	input  wire logic             empty,
	output logic                  pop,
	luds_stream_if.source         point_stream
);

	logic [1:0] idx_q;
	logic       valid_q;
	luds_pkg::out_item_t item_q;

	logic load;
	logic is_last;
	logic [1:0] last_idx;

	assign last_idx = 2'(head.count - 3'd1);
	assign load = !empty && (!valid_q || point_stream.ready);
	assign is_last = (idx_q == last_idx);
	assign pop = load && is_last;

	assign point_stream.valid = valid_q;
	assign point_stream.payload = item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			item_q.code_point <= head.code[idx_q];
			item_q.passed_raw <= head.raw[idx_q];
			item_q.run_last <= is_last;
			item_q.text_done <= is_last && head.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (point_stream.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
